### design/semver_string_parser_defines.svh
// Assertion macros for the semantic version parser.
// Included by the top level; no other dependencies.
`ifndef SEMVER_STRING_PARSER_DEFINES_SVH
`define SEMVER_STRING_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define SEMVER_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("semver_string_parser: same-cycle check failed");
`define SEMVER_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("semver_string_parser: next-cycle check failed");
`else
`define SEMVER_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SEMVER_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### design/semver_pkg.sv
// Shared types and constants of the semantic version parser.
// No dependencies; used by the controller, the datapath and the top level.
package semver_pkg;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 64;
   localparam int LEN_W      = 5;
   localparam int NUM_W      = 16;
   localparam int LABEL_CAP  = 32;

   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_DOT  = 8'h2E;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_LA   = 8'h61;
   localparam logic [7:0] CH_LZ   = 8'h7A;
   localparam logic [7:0] CH_UA   = 8'h41;
   localparam logic [7:0] CH_UZ   = 8'h5A;

   localparam logic KIND_SUMMARY = 1'b0;
   localparam logic KIND_LABEL   = 1'b1;

   typedef struct packed {
      logic take_digit;
      logic sep_major;
      logic sep_minor;
      logic set_error;
      logic label_write;
      logic summary_load;
      logic summary_ok;
      logic summary_has;
      logic clear_label;
      logic read_char;
      logic send_char;
   } semver_cmd_type;

   typedef struct packed {
      logic is_term;
      logic is_digit;
      logic is_label_ch;
      logic is_dot;
      logic is_dash;
      logic num_empty;
      logic error;
      logic label_full;
      logic label_empty;
      logic strict;
      logic emit_last;
      logic slot_free;
   } semver_status_type;

endpackage

### design/semver_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module semver_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/semver_ctrl.sv
// Controller of the semantic version parser: parse phases and label emission.
// Depends on semver_pkg for the command and status structs.
module semver_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  semver_pkg::semver_status_type status,
   output semver_pkg::semver_cmd_type    cmd
);
   import semver_pkg::*;

   typedef enum logic [5:0] {
      ST_MAJOR = 6'b000001,
      ST_MINOR = 6'b000010,
      ST_PATCH = 6'b000100,
      ST_LABEL = 6'b001000,
      ST_READ  = 6'b010000,
      ST_SEND  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      parsing;
   logic      accept;
   logic      ok;
   logic      has;

   assign parsing    = (state_ff == ST_MAJOR) || (state_ff == ST_MINOR) ||
                       (state_ff == ST_PATCH) || (state_ff == ST_LABEL);
   assign req_tready = parsing && status.slot_free;
   assign accept     = req_tvalid && req_tready;

   // A string is good only if it got through the patch number, with a
   // non-empty label when one was started.
   assign has = (state_ff == ST_LABEL);
   assign ok  = !status.error &&
                (((state_ff == ST_PATCH) && !status.num_empty) ||
                 (has && !status.label_empty && !status.strict));

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff) inside
         ST_MAJOR, ST_MINOR, ST_PATCH, ST_LABEL: begin
            if (accept) begin
               if (status.is_term) begin
                  cmd.summary_load = 1'b1;
                  cmd.summary_ok   = ok;
                  cmd.summary_has  = has;
                  if (ok && has) begin
                     state_in = ST_READ;
                  end else begin
                     cmd.clear_label = 1'b1;
                     state_in        = ST_MAJOR;
                  end
               end else if (status.error) begin
                  // Characters after an error are dropped until the terminator.
               end else if (has) begin
                  if (!status.is_label_ch || status.label_full) begin
                     cmd.set_error = 1'b1;
                  end else begin
                     cmd.label_write = 1'b1;
                  end
               end else if (status.is_digit) begin
                  cmd.take_digit = 1'b1;
               end else if (status.num_empty) begin
                  cmd.set_error = 1'b1;
               end else if (status.is_dot && (state_ff == ST_MAJOR)) begin
                  cmd.sep_major = 1'b1;
                  state_in      = ST_MINOR;
               end else if (status.is_dot && (state_ff == ST_MINOR)) begin
                  cmd.sep_minor = 1'b1;
                  state_in      = ST_PATCH;
               end else if (status.is_dash && (state_ff == ST_PATCH)) begin
                  state_in = ST_LABEL;
               end else begin
                  cmd.set_error = 1'b1;
               end
            end
         end
         ST_READ: begin
            cmd.read_char = 1'b1;
            state_in      = ST_SEND;
         end
         ST_SEND: begin
            if (status.slot_free) begin
               cmd.send_char = 1'b1;
               if (status.emit_last) begin
                  cmd.clear_label = 1'b1;
                  state_in        = ST_MAJOR;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_MAJOR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MAJOR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/semver_dp.sv
// Datapath of the semantic version parser: number accumulation, label store,
// strict mode register and the result output register.
// Depends on semver_pkg and semver_ram.
module semver_dp #(
   parameter int LABEL_LIMIT = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data,
   input  logic [semver_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  semver_pkg::semver_cmd_type           cmd,
   output semver_pkg::semver_status_type        status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [semver_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);
   import semver_pkg::*;

   localparam int EffLimit = (LABEL_LIMIT > LABEL_CAP) ? LABEL_CAP : LABEL_LIMIT;
   localparam int AddrW    = (EffLimit > 1) ? $clog2(EffLimit) : 1;

   logic [7:0]       ch;
   logic [3:0]       digit;
   logic [19:0]      acc_wide;
   logic             dig_zero_first;
   logic             dig_ovf;

   logic [NUM_W-1:0] acc_ff, acc_in;
   logic             lz_ff, lz_in;
   logic             err_ff, err_in;
   logic [NUM_W-1:0] major_ff, minor_ff;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] emit_idx_ff, emit_idx_in;
   logic             strict_ff;

   logic             out_valid_ff;
   logic             out_kind_ff;
   logic             out_ok_ff;
   logic [NUM_W-1:0] out_major_ff, out_minor_ff, out_patch_ff;
   logic             out_has_ff;
   logic [LEN_W-1:0] out_len_ff;
   logic [7:0]       out_char_ff;
   logic             out_last_ff;
   logic [7:0]       rd_data;
   logic             good_label;

   assign ch    = req_tdata;
   assign digit = 4'(ch - CH_ZERO);

   // Times ten as two shifted copies plus the new digit.
   assign acc_wide       = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {16'h0000, digit};
   assign dig_zero_first = (acc_ff == '0) && (digit == 4'd0);
   assign dig_ovf        = |acc_wide[19:16];

   assign status.is_term     = (ch == CH_NUL);
   assign status.is_digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign status.is_label_ch = status.is_digit || (ch == CH_DOT) ||
                               ((ch >= CH_LA) && (ch <= CH_LZ)) ||
                               ((ch >= CH_UA) && (ch <= CH_UZ));
   assign status.is_dot      = (ch == CH_DOT);
   assign status.is_dash     = (ch == CH_DASH);
   assign status.num_empty   = (acc_ff == '0) && !lz_ff;
   assign status.error       = err_ff;
   assign status.label_full  = (count_ff >= LEN_W'(EffLimit - 1));
   assign status.label_empty = (count_ff == '0);
   assign status.strict      = strict_ff;
   assign status.emit_last   = ((emit_idx_ff + LEN_W'(1)) == count_ff);
   assign status.slot_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      acc_in      = acc_ff;
      lz_in       = lz_ff;
      err_in      = err_ff;
      count_in    = count_ff;
      emit_idx_in = emit_idx_ff;
      if (cmd.take_digit) begin
         if (lz_ff) begin
            err_in = 1'b1;
         end else if (dig_zero_first) begin
            lz_in = 1'b1;
         end else if (dig_ovf) begin
            err_in = 1'b1;
         end else begin
            acc_in = acc_wide[NUM_W-1:0];
         end
      end
      if (cmd.set_error) begin
         err_in = 1'b1;
      end
      if (cmd.sep_major || cmd.sep_minor || cmd.summary_load) begin
         acc_in = '0;
         lz_in  = 1'b0;
      end
      if (cmd.summary_load) begin
         err_in = 1'b0;
      end
      if (cmd.label_write) begin
         count_in = count_ff + LEN_W'(1);
      end
      if (cmd.send_char) begin
         emit_idx_in = emit_idx_ff + LEN_W'(1);
      end
      if (cmd.clear_label) begin
         count_in    = '0;
         emit_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         lz_ff       <= 1'b0;
         err_ff      <= 1'b0;
         count_ff    <= '0;
         emit_idx_ff <= '0;
         strict_ff   <= 1'b0;
      end else begin
         acc_ff      <= acc_in;
         lz_ff       <= lz_in;
         err_ff      <= err_in;
         count_ff    <= count_in;
         emit_idx_ff <= emit_idx_in;
         if (csr_wr_en) begin
            strict_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sep_major) begin
         major_ff <= acc_ff;
      end
      if (cmd.sep_minor) begin
         minor_ff <= acc_ff;
      end
   end

   semver_ram #(
      .WIDTH (8),
      .DEPTH (EffLimit)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (cmd.label_write),
      .wr_addr (count_ff[AddrW-1:0]),
      .wr_data (ch),
      .rd_en   (cmd.read_char),
      .rd_addr (emit_idx_ff[AddrW-1:0]),
      .rd_data (rd_data)
   );

   assign good_label = cmd.summary_ok && cmd.summary_has;

   // Output register: valid is control state, the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.summary_load || cmd.send_char) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.summary_load) begin
         out_kind_ff  <= KIND_SUMMARY;
         out_ok_ff    <= cmd.summary_ok;
         out_major_ff <= cmd.summary_ok ? major_ff : '0;
         out_minor_ff <= cmd.summary_ok ? minor_ff : '0;
         out_patch_ff <= cmd.summary_ok ? acc_ff : '0;
         out_has_ff   <= good_label;
         out_len_ff   <= good_label ? count_ff : '0;
         out_char_ff  <= '0;
         out_last_ff  <= !good_label;
      end else if (cmd.send_char) begin
         out_kind_ff  <= KIND_LABEL;
         out_ok_ff    <= 1'b0;
         out_major_ff <= '0;
         out_minor_ff <= '0;
         out_patch_ff <= '0;
         out_has_ff   <= 1'b0;
         out_len_ff   <= '0;
         out_char_ff  <= rd_data;
         out_last_ff  <= status.emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff, out_len_ff, out_has_ff, out_patch_ff,
                        out_minor_ff, out_major_ff, out_ok_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### design/semver_string_parser.sv
// Semantic version parser: one character word per cycle while parsing; the summary
// word is loaded at the edge that accepts the terminator and is offered the next cycle.
// Each label character then passes through the label RAM read and then the output
// register, and input is held off until the last label word is loaded.
// A result word that waits for rsp_tready also holds off input and label emission.
// Reset is synchronous and active high: it clears the parse state and the strict
// mode register; the label RAM is not cleared.
`include "semver_string_parser_defines.svh"

module semver_string_parser #(
   parameter int LABEL_LIMIT = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,  // strict_numeric
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [semver_pkg::REQ_DATA_W-1:0] req_tdata,    // ch
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // valid_res, major, minor, patch, has_pre, label_length, label_char, zero pad
   output logic [semver_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                              rsp_tuser,    // kind
   output logic                              rsp_tlast     // last
);
   import semver_pkg::*;

   semver_cmd_type    cmd;
   semver_status_type status;

   semver_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   semver_dp #(
      .LABEL_LIMIT (LABEL_LIMIT)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // A terminator always produces a summary in the following cycle.
   `SEMVER_ASSERT_NXT(a_term_gives_summary, clock, reset,
      req_tvalid && req_tready && (req_tdata == CH_NUL),
      rsp_tvalid && (rsp_tuser == KIND_SUMMARY))
   // An invalid summary ends the string.
   `SEMVER_ASSERT_IMP(a_invalid_is_last, clock, reset,
      rsp_tvalid && (rsp_tuser == KIND_SUMMARY) && !rsp_tdata[0], rsp_tlast)
   // Label words carry nothing but the character.
   `SEMVER_ASSERT_IMP(a_label_word_clean, clock, reset,
      rsp_tvalid && (rsp_tuser == KIND_LABEL), rsp_tdata[54:0] == '0)

endmodule

### verif/semver_string_parser_tb.sv
// Self-checking testbench for semver_string_parser: a short table of directed strings, then
// random version strings under several idle patterns, each result word checked field by field.
// Depends on semver_pkg and the parser RTL only.
module semver_string_parser_tb;
   import semver_pkg::*;

   localparam int LABEL_LIMIT   = 32;
   localparam int LABEL_ROOM    = (LABEL_LIMIT > 32) ? 32 : LABEL_LIMIT;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 5;
   localparam int PHASE_CHARS   = 40;
   localparam int DIR_ROWS      = 6;

   typedef enum logic [1:0] {SEG_MAJOR, SEG_MINOR, SEG_PATCH, SEG_LABEL} segment_type;

   typedef struct packed {
      logic        kind;
      logic        ok;
      logic [15:0] major;
      logic [15:0] minor;
      logic [15:0] patch;
      logic        has_pre;
      logic [4:0]  len;
      logic [7:0]  ch;
      logic        last;
   } version_word_type;

   localparam version_word_type REJECT_WORD = '{kind: KIND_SUMMARY, ok: 1'b0, major: 16'd0,
      minor: 16'd0, patch: 16'd0, has_pre: 1'b0, len: 5'd0, ch: 8'd0, last: 1'b1};
   localparam version_word_type EXTREME_WORD = '{kind: KIND_SUMMARY, ok: 1'b1, major: 16'd0,
      minor: 16'd65535, patch: 16'd9, has_pre: 1'b0, len: 5'd0, ch: 8'd0, last: 1'b1};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic                  csr_wr_data = 1'b0;
   logic                  req_tvalid  = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tready  = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   // Directed strings; rows marked typed carry their expected summary inline.
   string            dir_text  [DIR_ROWS] = '{"", "0.65535.9", "1..2", "01", "9.9.9x",
                                              "1.2.3-a.Z9"};
   bit               dir_typed [DIR_ROWS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
   version_word_type dir_exp   [DIR_ROWS] = '{REJECT_WORD, EXTREME_WORD, REJECT_WORD,
                                              REJECT_WORD, REJECT_WORD, REJECT_WORD};

   bit phase_strict [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
   int phase_send   [PHASES] = '{0, 58, 0, 6, 0};
   int phase_recv   [PHASES] = '{0, 0, 58, 6, 0};

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int quiet_cycles   = 0;

   version_word_type words_due[$];

   // Parser state as the predictor sees it.
   bit          strict_mode;
   segment_type seg;
   logic [16:0] acc;
   bit          lead_zero;
   logic [15:0] major_val;
   logic [15:0] minor_val;
   bit          parse_err;
   int          label_n;
   logic [7:0]  label_bytes [LABEL_ROOM];

   semver_string_parser #(
      .LABEL_LIMIT(LABEL_LIMIT)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic void clear_parse();
      seg       = SEG_MAJOR;
      acc       = '0;
      lead_zero = 1'b0;
      major_val = '0;
      minor_val = '0;
      parse_err = 1'b0;
      label_n   = 0;
   endfunction

   function automatic bit is_digit_ch(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_alnum_ch(input logic [7:0] c);
      return is_digit_ch(c) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
   endfunction

   function automatic bit number_empty();
      return acc == 0 && !lead_zero;
   endfunction

   // Terminator: queue the summary word and any label words, then start over.
   function automatic void close_string(input bit keep);
      bit               ok;
      bit               has;
      int               n;
      version_word_type w;
      ok  = !parse_err;
      has = (seg == SEG_LABEL);
      if (seg == SEG_MAJOR || seg == SEG_MINOR) ok = 1'b0;
      if (seg == SEG_PATCH && number_empty()) ok = 1'b0;
      if (has && label_n == 0) ok = 1'b0;
      if (has && strict_mode) ok = 1'b0;
      n = has ? label_n : 0;
      if (keep && !ok) begin
         words_due.push_back(REJECT_WORD);
      end else if (keep) begin
         w         = '0;
         w.kind    = KIND_SUMMARY;
         w.ok      = 1'b1;
         w.major   = major_val;
         w.minor   = minor_val;
         w.patch   = acc[15:0];
         w.has_pre = has;
         w.len     = 5'(n);
         w.last    = (n == 0);
         words_due.push_back(w);
         for (int i = 0; i < n; i++) begin
            w      = '0;
            w.kind = KIND_LABEL;
            w.ch   = label_bytes[i];
            w.last = (i == n - 1);
            words_due.push_back(w);
         end
      end
      clear_parse();
   endfunction

   function automatic void parse_char(input logic [7:0] c, input bit keep);
      int v;
      if (c == CH_NUL) begin
         close_string(keep);
         return;
      end
      if (parse_err) return;
      if (seg == SEG_LABEL) begin
         if (!is_alnum_ch(c) && c != CH_DOT) parse_err = 1'b1;
         else if (label_n + 1 >= LABEL_ROOM) parse_err = 1'b1;
         else begin
            label_bytes[label_n] = c;
            label_n++;
         end
         return;
      end
      if (is_digit_ch(c)) begin
         v = int'(acc) * 10 + int'(c - CH_ZERO);
         if (lead_zero) parse_err = 1'b1;
         else if (acc == 0 && c == CH_ZERO) lead_zero = 1'b1;
         else if (v > 65535) parse_err = 1'b1;
         else acc = 17'(v);
         return;
      end
      if (number_empty()) begin
         parse_err = 1'b1;
         return;
      end
      if (c == CH_DOT && seg == SEG_MAJOR) begin
         major_val = acc[15:0];
         seg = SEG_MINOR;
      end else if (c == CH_DOT && seg == SEG_MINOR) begin
         minor_val = acc[15:0];
         seg = SEG_PATCH;
      end else if (c == CH_DASH && seg == SEG_PATCH) begin
         // The patch value stays in the accumulator through the label.
         seg = SEG_LABEL;
         return;
      end else begin
         parse_err = 1'b1;
         return;
      end
      acc       = '0;
      lead_zero = 1'b0;
   endfunction

   function automatic void add_text(ref logic [7:0] s[$], input string t);
      for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
   endfunction

   function automatic string number_text();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return "0";
      if (pick < 13) return "65535";
      if (pick < 18) return $sformatf("%0d", $urandom_range(65536, 99999));
      if (pick < 22) return $sformatf("0%0d", $urandom_range(0, 99));
      if (pick < 25) return "";
      if (pick < 60) return $sformatf("%0d", $urandom_range(1, 9));
      if (pick < 85) return $sformatf("%0d", $urandom_range(10, 999));
      return $sformatf("%0d", $urandom_range(1000, 65535));
   endfunction

   function automatic logic [7:0] label_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return 8'($urandom_range(1, 255));
      if (pick < 15) return CH_DOT;
      if (pick < 40) return 8'(CH_ZERO + $urandom_range(0, 9));
      if (pick < 70) return 8'(CH_LA + $urandom_range(0, 25));
      return 8'(CH_UA + $urandom_range(0, 25));
   endfunction

   // Mostly well-formed strings with random content, some with one byte broken,
   // and some plain noise.
   function automatic void random_string(ref logic [7:0] s[$]);
      int pick;
      int len_pick;
      int n;
      int pos;
      pick = $urandom_range(0, 99);
      if (pick >= 85) begin
         n = $urandom_range(0, 8);
         repeat (n) s.push_back(8'($urandom_range(1, 255)));
         return;
      end
      add_text(s, number_text());
      s.push_back(CH_DOT);
      add_text(s, number_text());
      s.push_back(CH_DOT);
      add_text(s, number_text());
      if ($urandom_range(0, 1) == 1) begin
         s.push_back(CH_DASH);
         len_pick = $urandom_range(0, 99);
         if (len_pick < 4) n = 0;
         else if (len_pick < 14) n = $urandom_range(LABEL_ROOM - 3, LABEL_ROOM + 1);
         else n = $urandom_range(1, 6);
         repeat (n) s.push_back(label_char());
      end
      if (pick >= 70) begin
         pos = $urandom_range(0, s.size() - 1);
         if ($urandom_range(0, 1) == 1) s[pos] = 8'($urandom_range(1, 255));
         else s.delete(pos);
      end
   endfunction

   task automatic send_char(input logic [7:0] c, input bit keep);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_char(c, keep);
   endtask

   task automatic send_string(input logic [7:0] text[$], input bit typed,
                              input version_word_type typed_word);
      text.push_back(CH_NUL);
      foreach (text[i]) send_char(text[i], !typed);
      if (typed) words_due.push_back(typed_word);
   endtask

   // Let every queued word drain before the register may change.
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_strict(input bit value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      strict_mode = value;
   endtask

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : rsp_sink
      version_word_type got;
      version_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind    = rsp_tuser;
            got.ok      = rsp_tdata[0];
            got.major   = rsp_tdata[16:1];
            got.minor   = rsp_tdata[32:17];
            got.patch   = rsp_tdata[48:33];
            got.has_pre = rsp_tdata[49];
            got.len     = rsp_tdata[54:50];
            got.ch      = rsp_tdata[62:55];
            got.last    = rsp_tlast;
            if (words_due.size() == 0) begin
               $error("result word 0x%0h arrived with nothing expected", got);
               mismatches++;
            end else begin
               want = words_due.pop_front();
               check_field("kind", want.kind, got.kind);
               check_field("valid_res", want.ok, got.ok);
               check_field("major", want.major, got.major);
               check_field("minor", want.minor, got.minor);
               check_field("patch", want.patch, got.patch);
               check_field("has_pre", want.has_pre, got.has_pre);
               check_field("label_length", want.len, got.len);
               check_field("label_char", want.ch, got.ch);
               check_field("last", want.last, got.last);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [7:0] text[$];
      int         chars;
      strict_mode = 1'b0;
      clear_parse();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         text.delete();
         add_text(text, dir_text[r]);
         send_string(text, dir_typed[r], dir_exp[r]);
      end
      finish_phase();

      for (int p = 0; p < PHASES; p++) begin
         write_strict(phase_strict[p]);
         send_gap_pct   = phase_send[p];
         recv_stall_pct = phase_recv[p];
         chars = 0;
         while (chars < PHASE_CHARS) begin
            text.delete();
            random_string(text);
            chars += text.size() + 1;
            send_string(text, 1'b0, REJECT_WORD);
         end
         finish_phase();
      end

      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
